>>> design/fdb_pkg.sv
// Shared types and constants for the first differing bit finder.
package fdb_pkg;

    localparam int MAX_KEY_BYTES_DEF = 512;
    localparam int START_W           = 12;
    localparam int END_W             = 13;
    localparam int POS_OUT_W         = 12;

    typedef enum logic [0:0] {
        ACT_COMPARE   = 1'b0,
        ACT_ZERO_TEST = 1'b1
    } fdb_action_t;

    typedef struct packed {
        fdb_action_t          action;
        logic [7:0]           src_byte;
        logic [7:0]           dst_byte;
        logic [START_W-1:0]   start_bit;
        logic [END_W-1:0]     end_bit;
        logic                 last;
    } fdb_item_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] bit_pos;
    } fdb_result_t;

endpackage

>>> design/first_differing_bit_finder_core.sv
// Top level of the first differing bit finder: input and result registers.
//
// Usage: a job is a run of beats on the s_ channel, one byte of each key per
// beat, byte 0 first, the final beat flagged by s_tlast. The action in
// s_tuser and the bit window [start_bit, end_bit) are taken from the first
// beat of a job; on later beats they are don't-care. Bits are numbered from
// the MSB of byte 0. In zero-test mode dst_byte is ignored and the block
// finds the first set bit of the first key inside the window.
// One result beat per job leaves on the m_ channel: found and bit_pos.
// Throughput: one beat per cycle, but a job-ending beat can wait while a result
// is pending (see below). The last beat of a job lands in the input register;
// the compare/encode logic then loads the result register, which sets m_tvalid.
// Bytes past MAX_KEY_BYTES in a job are ignored.
// Reset (aresetn low, synchronous) empties both registers and abandons any
// open job. When the receiver stalls with a result pending, beats that do
// not end a job keep flowing; a job-ending beat waits in the input register
// and s_tready drops until the pending result is taken.
module first_differing_bit_finder_core
    import fdb_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // src_byte, dst_byte, start_bit, end_bit, zero pad
    input  logic [0:0]  s_tuser,   // action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // found, bit_pos, zero pad
);

    logic        in_valid_reg, in_valid_next;
    fdb_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    fdb_result_t out_result_reg;
    fdb_result_t result;
    logic        out_free;
    logic        step;
    fdb_item_t   s_item;

    assign s_item.action    = fdb_action_t'(s_tuser[0]);
    assign s_item.src_byte  = s_tdata[7:0];
    assign s_item.dst_byte  = s_tdata[15:8];
    assign s_item.start_bit = s_tdata[27:16];
    assign s_item.end_bit   = s_tdata[40:28];
    assign s_item.last      = s_tlast;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!in_item_reg.last || out_free);
    assign s_tready = !in_valid_reg || step;

    fdb_accum #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (step && in_item_reg.last) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
        if (step && in_item_reg.last) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.bit_pos, out_result_reg.found};

endmodule

>>> design/fdb_byte_eval.sv
// Window mask, byte difference and leading-one encode for one key byte.
module fdb_byte_eval
    import fdb_pkg::*;
#(
    parameter int CNT_W = 10,
    parameter int CMP_W = 13
) (
    input  logic [CNT_W-1:0]   byte_idx,
    input  logic               in_range,
    input  logic [START_W-1:0] win_start,
    input  logic [END_W-1:0]   win_end,
    input  fdb_action_t        mode,
    input  logic [7:0]         src_byte,
    input  logic [7:0]         dst_byte,
    output logic               hit,
    output logic [CMP_W-1:0]   hit_pos
);

    logic [CMP_W-1:0] base;
    logic [CMP_W-1:0] start_ext;
    logic [CMP_W-1:0] end_ext;
    logic [7:0]       mask;
    logic [7:0]       diff;
    logic [2:0]       lead;

    assign base      = CMP_W'({byte_idx, 3'b000});
    assign start_ext = CMP_W'(win_start);
    assign end_ext   = CMP_W'(win_end);

    always_comb begin
        logic [CMP_W-1:0] pos;
        for (int i = 0; i < 8; i++) begin
            pos = base + CMP_W'(i);
            mask[7-i] = (pos >= start_ext) && (pos < end_ext);
        end
    end

    assign diff = (src_byte ^ ((mode == ACT_ZERO_TEST) ? 8'h00 : dst_byte))
                  & mask & {8{in_range}};

    // bit 7 is the first bit of the byte
    always_comb begin
        lead = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (diff[7-i]) begin
                lead = 3'(i);
            end
        end
    end

    assign hit     = |diff;
    assign hit_pos = base + CMP_W'(lead);

endmodule

>>> design/fdb_accum.sv
// Per-job state: window latch, byte counter and first hit tracking.
module fdb_accum
    import fdb_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  fdb_item_t   item,
    output fdb_result_t result
);

    localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int CMP_W = (CNT_W + 3 > END_W) ? CNT_W + 3 : END_W;

    logic                 job_open_reg,     job_open_next;
    fdb_action_t          job_mode_reg,     job_mode_next;
    logic [START_W-1:0]   window_start_reg, window_start_next;
    logic [END_W-1:0]     window_end_reg,   window_end_next;
    logic [CNT_W-1:0]     byte_count_reg,   byte_count_next;
    logic                 hit_seen_reg,     hit_seen_next;
    logic [POS_OUT_W-1:0] hit_position_reg, hit_position_next;

    fdb_action_t          mode;
    logic [START_W-1:0]   win_start;
    logic [END_W-1:0]     win_end;
    logic [CNT_W-1:0]     cnt;
    logic                 seen;
    logic [POS_OUT_W-1:0] seen_pos;
    logic                 in_range;
    logic                 hit;
    logic [CMP_W-1:0]     hit_pos;
    logic                 take_hit;
    logic                 found_now;
    logic [POS_OUT_W-1:0] pos_now;

    assign mode      = job_open_reg ? job_mode_reg     : item.action;
    assign win_start = job_open_reg ? window_start_reg : item.start_bit;
    assign win_end   = job_open_reg ? window_end_reg   : item.end_bit;
    assign cnt       = job_open_reg ? byte_count_reg   : '0;
    assign seen      = job_open_reg ? hit_seen_reg     : 1'b0;
    assign seen_pos  = job_open_reg ? hit_position_reg : '0;
    assign in_range  = cnt < CNT_W'(MAX_KEY_BYTES);

    fdb_byte_eval #(
        .CNT_W (CNT_W),
        .CMP_W (CMP_W)
    ) u_eval (
        .byte_idx  (cnt),
        .in_range  (in_range),
        .win_start (win_start),
        .win_end   (win_end),
        .mode      (mode),
        .src_byte  (item.src_byte),
        .dst_byte  (item.dst_byte),
        .hit       (hit),
        .hit_pos   (hit_pos)
    );

    assign take_hit  = hit && !seen;
    assign found_now = seen || hit;
    assign pos_now   = take_hit ? hit_pos[POS_OUT_W-1:0] : seen_pos;

    assign result.found   = found_now;
    assign result.bit_pos = found_now ? pos_now : '0;

    always_comb begin
        job_open_next     = job_open_reg;
        job_mode_next     = job_mode_reg;
        window_start_next = window_start_reg;
        window_end_next   = window_end_reg;
        byte_count_next   = byte_count_reg;
        hit_seen_next     = hit_seen_reg;
        hit_position_next = hit_position_reg;
        if (step) begin
            if (item.last) begin
                job_open_next     = 1'b0;
                byte_count_next   = '0;
                hit_seen_next     = 1'b0;
                hit_position_next = '0;
            end else begin
                job_open_next     = 1'b1;
                job_mode_next     = mode;
                window_start_next = win_start;
                window_end_next   = win_end;
                byte_count_next   = in_range ? cnt + CNT_W'(1) : cnt;
                hit_seen_next     = found_now;
                hit_position_next = pos_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_open_reg     <= 1'b0;
            job_mode_reg     <= ACT_COMPARE;
            window_start_reg <= '0;
            window_end_reg   <= '0;
            byte_count_reg   <= '0;
            hit_seen_reg     <= 1'b0;
            hit_position_reg <= '0;
        end else begin
            job_open_reg     <= job_open_next;
            job_mode_reg     <= job_mode_next;
            window_start_reg <= window_start_next;
            window_end_reg   <= window_end_next;
            byte_count_reg   <= byte_count_next;
            hit_seen_reg     <= hit_seen_next;
            hit_position_reg <= hit_position_next;
        end
    end

endmodule
